[src/swsup_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Service watchdog supervisor package
// Shared types, codes and default constants for the supervisor core.
// ----------------------------------------------------------------------------
package swsup_pkg;

    localparam int SWSUP_NUM_SLOTS = 8;

    // Configuration register reset values
    localparam logic [31:0] COOLDOWN_RESET   = 32'd30000;
    localparam logic [31:0] WINDOW_RESET     = 32'd600000;
    localparam logic [7:0]  WIN_MAX_RESET    = 8'd3;
    localparam logic [15:0] STACK_CRIT_RESET = 16'd64;

    // Configuration register indexes
    localparam logic [1:0] CFG_COOLDOWN   = 2'd0;
    localparam logic [1:0] CFG_WINDOW     = 2'd1;
    localparam logic [1:0] CFG_WIN_MAX    = 2'd2;
    localparam logic [1:0] CFG_STACK_CRIT = 2'd3;

    // Request types
    localparam logic [1:0] REQ_REGISTER  = 2'd0;
    localparam logic [1:0] REQ_HEARTBEAT = 2'd1;
    localparam logic [1:0] REQ_CHECK     = 2'd2;

    // Actions
    localparam logic [1:0] ACT_NONE     = 2'd0;
    localparam logic [1:0] ACT_RESTART  = 2'd1;
    localparam logic [1:0] ACT_COOLDOWN = 2'd2;
    localparam logic [1:0] ACT_ESCALATE = 2'd3;

    // Failure causes
    localparam logic [2:0] CAUSE_NONE      = 3'd0;
    localparam logic [2:0] CAUSE_TASK_GONE = 3'd1;
    localparam logic [2:0] CAUSE_STACK     = 3'd2;
    localparam logic [2:0] CAUSE_NO_HB     = 3'd3;
    localparam logic [2:0] CAUSE_HEALTH    = 3'd4;

    localparam logic [7:0] WIN_CNT_MAX = 8'hFF;

    // One slot's record as kept in the slot memory.
    typedef struct packed {
        logic [31:0] quiet;
        logic [31:0] last_hb;
        logic [15:0] stack_low;
        logic [31:0] restart_cnt;
        logic [31:0] last_restart;
        logic [31:0] win_start;
        logic [7:0]  win_cnt;
        logic        stack_seen;
        logic        restarted;
        logic        win_open;
    } slot_rec_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REG_WR,
        S_RD,
        S_LD,
        S_STK,
        S_COOL,
        S_WIN,
        S_WB,
        S_OUT
    } state_t;

endpackage

[src/swsup_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module swsup_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

[src/service_watchdog_supervisor_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Service watchdog supervisor core
// Slot table with heartbeat, stack and health checks and restart rate limit.
// ----------------------------------------------------------------------------
// A rejected word goes straight to output, a register writes a new record,
// and a check adds stack, cooldown and window steps to the heartbeat path (one
// shared 32-bit subtract and compare unit evaluates heartbeat age, cooldown and
// window in turn, around a read-modify-write of the slot record in one RAM).
// One word in flight; in_ready returns the cycle after the result is taken.
// Reset clears the slot count, the escalation count and the sequencer, and
// loads the configuration defaults; slot records are written on register.
module service_watchdog_supervisor_core
    import swsup_pkg::*;
#(
    parameter int NUM_SLOTS = SWSUP_NUM_SLOTS
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [2:0]  service_slot,
    input  logic [31:0] now_ms,
    input  logic [31:0] quiet_limit_ms,
    input  logic        task_alive,
    input  logic [15:0] stack_free_words,
    input  logic        health_ok,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        accepted,
    output logic [1:0]  action,
    output logic [2:0]  cause,
    output logic [2:0]  slot_out,
    output logic [31:0] restart_total,
    output logic [15:0] stack_low_mark,
    output logic [31:0] escalation_total
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);
    localparam int REC_W = $bits(slot_rec_t);

    state_t state_reg, state_next;

    logic [31:0]      cooldown_reg;
    logic [31:0]      window_reg;
    logic [7:0]       win_max_reg;
    logic [15:0]      stack_crit_reg;
    logic [CNT_W-1:0] slots_used_reg, slots_used_next;
    logic [31:0]      esc_reg, esc_next;

    logic [1:0]       req_reg, req_next;
    logic [31:0]      now_reg, now_next;
    logic             alive_reg, alive_next;
    logic [15:0]      sfw_reg, sfw_next;
    logic             healthy_reg, healthy_next;
    logic [IDX_W-1:0] addr_reg, addr_next;
    slot_rec_t        rec_reg, rec_next;
    logic             accepted_reg, accepted_next;
    logic [1:0]       action_reg, action_next;
    logic [2:0]       cause_reg, cause_next;
    logic [2:0]       slot_out_reg, slot_out_next;

    logic [CNT_W+2:0] slot_wide;
    logic [CNT_W+2:0] used_wide;
    logic             slot_ok;
    logic             table_full;

    logic [31:0]      sub_b;
    logic [31:0]      lim;
    logic [31:0]      diff;
    logic             diff_gt;
    logic             diff_lt;

    logic [7:0]       win_base;
    logic [7:0]       win_inc;

    logic             ram_wr_en;
    logic             ram_rd_en;
    logic [REC_W-1:0] ram_rd_data;

    assign slot_wide  = {{CNT_W{1'b0}}, service_slot};
    assign used_wide  = {3'b000, slots_used_reg};
    assign slot_ok    = slot_wide < used_wide;
    assign table_full = slots_used_reg == CNT_W'(NUM_SLOTS);

    swsup_ram #(
        .WIDTH (REC_W),
        .DEPTH (NUM_SLOTS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (addr_reg),
        .wr_data (rec_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (addr_reg),
        .rd_data (ram_rd_data)
    );

    // Shared subtract and compare unit: elapsed time against a limit.
    always_comb
    begin
        case (state_reg)
            S_COOL:
            begin
                sub_b = rec_reg.last_restart;
                lim   = cooldown_reg;
            end
            S_WIN:
            begin
                sub_b = rec_reg.win_start;
                lim   = window_reg;
            end
            default:
            begin
                sub_b = rec_reg.last_hb;
                lim   = rec_reg.quiet;
            end
        endcase
        diff    = now_reg - sub_b;
        diff_gt = diff > lim;
        diff_lt = diff < lim;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (req_type == REQ_REGISTER)
                    begin
                        state_next = table_full ? S_OUT : S_REG_WR;
                    end
                    else if (slot_ok &&
                             (req_type == REQ_HEARTBEAT || req_type == REQ_CHECK))
                    begin
                        state_next = S_RD;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_REG_WR: state_next = S_OUT;
            S_RD:     state_next = S_LD;
            S_LD:     state_next = (req_reg == REQ_HEARTBEAT) ? S_WB : S_STK;
            S_STK:    state_next = (cause_next != CAUSE_NONE) ? S_COOL : S_WB;
            S_COOL:   state_next = (rec_reg.restarted && diff_lt) ? S_WB : S_WIN;
            S_WIN:    state_next = S_WB;
            S_WB:     state_next = S_OUT;
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // Handshake and memory controls
    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        ram_wr_en = 1'b0;
        ram_rd_en = 1'b0;
        case (state_reg)
            S_IDLE:   in_ready  = 1'b1;
            S_RD:     ram_rd_en = 1'b1;
            S_REG_WR: ram_wr_en = 1'b1;
            S_WB:     ram_wr_en = 1'b1;
            S_OUT:    out_valid = 1'b1;
            default:  ;
        endcase
    end

    // Datapath
    always_comb
    begin
        slots_used_next = slots_used_reg;
        esc_next        = esc_reg;
        req_next        = req_reg;
        now_next        = now_reg;
        alive_next      = alive_reg;
        sfw_next        = sfw_reg;
        healthy_next    = healthy_reg;
        addr_next       = addr_reg;
        rec_next        = rec_reg;
        accepted_next   = accepted_reg;
        action_next     = action_reg;
        cause_next      = cause_reg;
        slot_out_next   = slot_out_reg;
        win_base        = rec_reg.win_cnt;
        win_inc         = rec_reg.win_cnt;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next     = req_type;
                    now_next     = now_ms;
                    alive_next   = task_alive;
                    sfw_next     = stack_free_words;
                    healthy_next = health_ok;
                    action_next  = ACT_NONE;
                    cause_next   = CAUSE_NONE;
                    if (req_type == REQ_REGISTER)
                    begin
                        accepted_next    = !table_full;
                        slot_out_next    = table_full ? 3'd0 : used_wide[2:0];
                        addr_next        = slots_used_reg[IDX_W-1:0];
                        rec_next         = '0;
                        rec_next.quiet   = quiet_limit_ms;
                        rec_next.last_hb = now_ms;
                    end
                    else
                    begin
                        accepted_next = slot_ok &&
                                        (req_type == REQ_HEARTBEAT || req_type == REQ_CHECK);
                        slot_out_next = service_slot;
                        addr_next     = slot_wide[IDX_W-1:0];
                    end
                end
            end
            S_REG_WR:
            begin
                slots_used_next = slots_used_reg + 1'b1;
            end
            S_LD:
            begin
                rec_next = slot_rec_t'(ram_rd_data);
                if (req_reg == REQ_HEARTBEAT)
                begin
                    rec_next.last_hb = now_reg;
                end
            end
            S_STK:
            begin
                if (!alive_reg)
                begin
                    cause_next = CAUSE_TASK_GONE;
                end
                else
                begin
                    // The stack mark is sampled only while the task exists.
                    if (!rec_reg.stack_seen || sfw_reg < rec_reg.stack_low)
                    begin
                        rec_next.stack_low  = sfw_reg;
                        rec_next.stack_seen = 1'b1;
                    end
                    if (sfw_reg < stack_crit_reg)
                    begin
                        cause_next = CAUSE_STACK;
                    end
                    else if (rec_reg.quiet != 32'd0 && diff_gt)
                    begin
                        cause_next = CAUSE_NO_HB;
                    end
                    else if (!healthy_reg)
                    begin
                        cause_next = CAUSE_HEALTH;
                    end
                end
            end
            S_COOL:
            begin
                if (rec_reg.restarted && diff_lt)
                begin
                    action_next = ACT_COOLDOWN;
                end
            end
            S_WIN:
            begin
                // A closed or expired window restarts its count at this time.
                if (!rec_reg.win_open || diff_gt)
                begin
                    win_base           = 8'd0;
                    rec_next.win_start = now_reg;
                end
                win_inc           = (win_base == WIN_CNT_MAX) ? win_base : win_base + 8'd1;
                rec_next.win_cnt  = win_inc;
                rec_next.win_open = 1'b1;
                if (win_inc <= win_max_reg)
                begin
                    rec_next.last_restart = now_reg;
                    rec_next.restarted    = 1'b1;
                    rec_next.last_hb      = now_reg;
                    rec_next.restart_cnt  = rec_reg.restart_cnt + 32'd1;
                    action_next           = ACT_RESTART;
                end
                else
                begin
                    esc_next    = esc_reg + 32'd1;
                    action_next = ACT_ESCALATE;
                end
            end
            default: ;
        endcase
    end

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            slots_used_reg <= '0;
            esc_reg        <= '0;
            cooldown_reg   <= COOLDOWN_RESET;
            window_reg     <= WINDOW_RESET;
            win_max_reg    <= WIN_MAX_RESET;
            stack_crit_reg <= STACK_CRIT_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            slots_used_reg <= slots_used_next;
            esc_reg        <= esc_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_COOLDOWN:   cooldown_reg   <= cfg_data;
                    CFG_WINDOW:     window_reg     <= cfg_data;
                    CFG_WIN_MAX:    win_max_reg    <= cfg_data[7:0];
                    CFG_STACK_CRIT: stack_crit_reg <= cfg_data[15:0];
                    default:        ;
                endcase
            end
        end
    end

    // Word and record registers
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        now_reg      <= now_next;
        alive_reg    <= alive_next;
        sfw_reg      <= sfw_next;
        healthy_reg  <= healthy_next;
        addr_reg     <= addr_next;
        rec_reg      <= rec_next;
        accepted_reg <= accepted_next;
        action_reg   <= action_next;
        cause_reg    <= cause_next;
        slot_out_reg <= slot_out_next;
    end

    assign accepted         = accepted_reg;
    assign action           = action_reg;
    assign cause            = cause_reg;
    assign slot_out         = slot_out_reg;
    assign restart_total    = accepted_reg ? rec_reg.restart_cnt : 32'd0;
    assign stack_low_mark   = (accepted_reg && rec_reg.stack_seen) ? rec_reg.stack_low : 16'd0;
    assign escalation_total = esc_reg;

    a_one_word_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while a result is pending");

    a_slot_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        slots_used_reg <= CNT_W'(NUM_SLOTS))
        else $error("slot count beyond table size");

    a_esc_only_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (esc_reg != $past(esc_reg)) |-> ($past(state_reg) == S_WIN))
        else $error("escalation count moved outside the window step");

    a_reject_is_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !accepted) |->
            (action == ACT_NONE && cause == CAUSE_NONE && restart_total == 32'd0))
        else $error("rejected word carries an action");

    a_action_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && action != ACT_NONE) |-> (cause != CAUSE_NONE))
        else $error("action without a failure cause");

endmodule
